[rtl/core/lpm_pkg.sv]
// Shared types, constants, tables and helper functions for the lattice polymer
// move engine. No dependencies; used by lpm_exp, the top level and the testbench.
`default_nettype none
package lpm_pkg;

    localparam int CHAINS     = 36;
    localparam int BEADS      = 20;
    localparam int BOX_X      = 7;
    localparam int BOX_Y      = 7;
    localparam int BOX_Z      = 20;
    localparam int BEAD_DEPTH = CHAINS * BEADS;
    localparam int SITES      = BOX_X * BOX_Y * BOX_Z;
    localparam int BEAD_AW    = $clog2(BEAD_DEPTH);
    localparam int SITE_AW    = $clog2(SITES);
    localparam int CNT_W      = 10;
    localparam int XW         = 3;
    localparam int YW         = 3;
    localparam int ZW         = 5;
    localparam int POS_W      = XW + YW + ZW;
    localparam int CW         = 8;
    localparam int EXP_BITS   = 13;
    localparam int EXP_PW     = 32;
    localparam int E_W        = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [3:0] SUM_LAST = 4'd13;
    localparam logic [3:0] EXP_LAST = 4'(EXP_BITS - 1);
    localparam logic signed [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
    localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

    typedef logic [1:0] t_action;
    localparam t_action ACT_LOAD = 2'd0;
    localparam t_action ACT_MOVE = 2'd1;
    localparam t_action ACT_READ = 2'd2;

    typedef logic [2:0] t_dir;
    localparam t_dir DIR_PX = 3'd0;
    localparam t_dir DIR_NX = 3'd1;
    localparam t_dir DIR_PY = 3'd2;
    localparam t_dir DIR_NY = 3'd3;
    localparam t_dir DIR_PZ = 3'd4;
    localparam t_dir DIR_NZ = 3'd5;

    localparam logic [0:0] REG_BEAD_ENERGY    = 1'd0;
    localparam logic [0:0] REG_OVERLAP_ENERGY = 1'd1;

    typedef logic signed [CW-1:0] t_sc;

    typedef struct packed {
        logic [ZW-1:0] z;
        logic [YW-1:0] y;
        logic [XW-1:0] x;
    } t_pos;

    typedef struct packed {
        t_sc x;
        t_sc y;
        t_sc z;
    } t_vec;

    typedef struct packed {
        t_action     action;
        logic [5:0]  chain;
        logic [4:0]  bead;
        t_dir        dir;
        t_pos        lpos;
        logic [31:0] rf;
    } t_item;

    typedef struct packed {
        logic                   accepted;
        t_pos                   pos;
        logic signed [E_W-1:0]  energy;
        logic                   status;
    } t_result;

    typedef struct packed {
        logic              done;
        logic              one;
        logic [EXP_PW-1:0] p;
    } t_exp_res;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_LOAD_RD, ST_LOAD_WR, ST_RD_BEAD,
        ST_RD_N1, ST_RD_N2, ST_GEOM1, ST_GEOM2, ST_SUM, ST_MUL1, ST_MUL2,
        ST_SAT, ST_DECIDE, ST_EXP, ST_UPD_RDO, ST_UPD_WRO, ST_UPD_RDT,
        ST_UPD_WRT, ST_DONE
    } t_state;

    localparam logic [EXP_PW-1:0] EXP_FACTOR [EXP_BITS] = '{
        32'd4278222805, 32'd4261543596, 32'd4228380000, 32'd4162825043,
        32'd4034748361, 32'd3790295335, 32'd3344923893, 32'd2605029349,
        32'd1580030168, 32'd581260616, 32'd78665071, 32'd1440802, 32'd483
    };

    function automatic logic [SITE_AW-1:0] f_site(input t_pos p);
        return SITE_AW'(int'(p.x) + BOX_X * int'(p.y) + BOX_X * BOX_Y * int'(p.z));
    endfunction

    function automatic t_pos f_neighbor(input t_pos p, input logic [2:0] i);
        t_pos n;
        n = p;
        case (i)
            DIR_PX: n.x = (p.x == XW'(BOX_X - 1)) ? '0 : p.x + XW'(1);
            DIR_NX: n.x = (p.x == '0) ? XW'(BOX_X - 1) : p.x - XW'(1);
            DIR_PY: n.y = (p.y == YW'(BOX_Y - 1)) ? '0 : p.y + YW'(1);
            DIR_NY: n.y = (p.y == '0) ? YW'(BOX_Y - 1) : p.y - YW'(1);
            DIR_PZ: n.z = (p.z == ZW'(BOX_Z - 1)) ? '0 : p.z + ZW'(1);
            DIR_NZ: n.z = (p.z == '0) ? ZW'(BOX_Z - 1) : p.z - ZW'(1);
            default: n = p;
        endcase
        return n;
    endfunction

    function automatic t_vec f_dir_vec(input t_dir d);
        t_vec v;
        v = '0;
        case (d)
            DIR_PX: v.x = 8'sd1;
            DIR_NX: v.x = -8'sd1;
            DIR_PY: v.y = 8'sd1;
            DIR_NY: v.y = -8'sd1;
            DIR_PZ: v.z = 8'sd1;
            DIR_NZ: v.z = -8'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic int f_min_image(input int d, input int len);
        int v;
        v = d;
        if (2 * v > len) begin
            v = v - len;
        end else if (2 * v <= -len) begin
            v = v + len;
        end
        return v;
    endfunction

    function automatic int f_wrap(input int v, input int len);
        int r;
        r = v;
        if (r < 0) begin
            r = r + len;
        end else if (r >= len) begin
            r = r - len;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/lpm_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for the bead position and site count stores.
`default_nettype none
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/core/lpm_exp.sv]
// Iterative exp(-d) unit in 0.32 fixed point, one table factor per cycle.
// Depends on lpm_pkg for the factor table and the result struct.
`default_nettype none
module lpm_exp (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire  [lpm_pkg::EXP_BITS-1:0] i_d,
    output lpm_pkg::t_exp_res           o_res
);

    logic                          r_busy;
    logic                          r_done;
    logic                          r_one;
    logic [3:0]                    r_bit;
    logic [lpm_pkg::EXP_BITS-1:0]  r_d;
    logic [lpm_pkg::EXP_PW-1:0]    r_p;
    logic [2*lpm_pkg::EXP_PW-1:0]  prod;

    assign prod = (2*lpm_pkg::EXP_PW)'(r_p) *
                  (2*lpm_pkg::EXP_PW)'(lpm_pkg::EXP_FACTOR[r_bit]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= '0;
                r_d    <= i_d;
                r_one  <= 1'b1;
                r_p    <= '0;
            end else if (r_busy) begin
                if (r_d[r_bit]) begin
                    if (r_one) begin
                        r_p   <= lpm_pkg::EXP_FACTOR[r_bit];
                        r_one <= 1'b0;
                    end else begin
                        r_p <= prod[2*lpm_pkg::EXP_PW-1:lpm_pkg::EXP_PW];
                    end
                end
                if (r_bit == lpm_pkg::EXP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_bit <= r_bit + 4'd1;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.one  = r_one;
    assign o_res.p    = r_p;

endmodule
`default_nettype wire

[rtl/core/lattice_polymer_metropolis_move.sv]
// Top level of the lattice polymer Metropolis move engine: sequencer, datapath
// and stores. Depends on lpm_pkg, lpm_ram and lpm_exp.
//
// Channel   Direction  Handshake                  Content
// s_axis    in         i_s_tvalid / o_s_tready    tuser action, tdata item fields
// m_axis    out        o_m_tvalid / i_m_tready    tuser status, tdata result fields
// cfg       in         i_cfg_valid / o_cfg_ready  register index and 16-bit data
//
// After reset the site count memory is cleared; no item is taken then.
// A load writes the bead position and updates its site count; a read fetches the position;
// an item with a bad action, index or load position goes straight to the result hand-over.
// A move reads the bead and its neighbours, then sums the site counts of the 13 sites of the
// energy sum over the site count memory port, and may run the 13-step exponential unit.
// A finished result waits in the output register while the next item is taken;
// the sequencer stalls only when a second result is ready and the first is not taken.
`default_nettype none
module lattice_polymer_metropolis_move (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // tuser: action[1:0]
    input  wire  [1:0]  i_s_tuser,
    // tdata: chain_index[5:0], bead_index[10:6], direction[13:11], load_x[16:14],
    // load_y[19:17], load_z[24:20], random_fraction[56:25], zero[63:57]
    input  wire  [63:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // tuser: status[0]
    output logic [0:0]  o_m_tuser,
    // tdata: accepted[0], bead_x[3:1], bead_y[6:4], bead_z[11:7],
    // energy_delta[35:12], zero[39:36]
    output logic [39:0] o_m_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    lpm_pkg::t_state  r_state, n_state;
    lpm_pkg::t_item   r_in;
    lpm_pkg::t_pos    r_o, r_n1, r_t;
    lpm_pkg::t_vec    r_va, r_vc;
    lpm_pkg::t_result r_res, r_out;
    logic                            r_ovalid;
    logic signed [15:0]              r_be;
    logic [15:0]                     r_oe;
    logic [lpm_pkg::SITE_AW-1:0]     r_clr;
    logic [3:0]                      r_step;
    logic [12:0]                     r_sum_old, r_sum_new;
    logic [lpm_pkg::CNT_W-1:0]       r_tcount;
    logic signed [31:0]              r_p1;
    logic [25:0]                     r_p2;
    logic signed [lpm_pkg::E_W-1:0]  r_e;

    logic                            b_we;
    logic [lpm_pkg::BEAD_AW-1:0]     b_waddr, b_raddr;
    logic [lpm_pkg::POS_W-1:0]       b_wdata, b_rdata;
    logic                            s_we;
    logic [lpm_pkg::SITE_AW-1:0]     s_waddr, s_raddr;
    logic [lpm_pkg::CNT_W-1:0]       s_wdata, s_rdata;
    logic                            exp_start;
    lpm_pkg::t_exp_res               exp_res;

    logic                            in_acc;
    logic                            is_end, item_bad, load_bad, dir_bad;
    logic                            e_nonpos, e_big, rf_zero, exp_acc, out_free;
    logic [lpm_pkg::BEAD_AW-1:0]     addr_k, addr_n1, addr_n2;
    logic [lpm_pkg::SITE_AW-1:0]     sum_addr;
    logic [3:0]                      prev_step;
    logic [lpm_pkg::CNT_W-1:0]       cnt_inc, cnt_dec;
    logic signed [14:0]              diff;
    logic signed [33:0]              esum;
    lpm_pkg::t_vec                   dv;
    int                              base;
    int                              dot;

    lpm_ram #(.WIDTH(lpm_pkg::POS_W), .DEPTH(lpm_pkg::BEAD_DEPTH)) u_bead_ram (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_waddr(b_waddr),
        .i_wdata(b_wdata),
        .i_raddr(b_raddr),
        .o_rdata(b_rdata)
    );

    lpm_ram #(.WIDTH(lpm_pkg::CNT_W), .DEPTH(lpm_pkg::SITES)) u_site_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    lpm_exp u_exp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(exp_start),
        .i_d    (r_e[lpm_pkg::EXP_BITS-1:0]),
        .o_res  (exp_res)
    );

    assign o_s_tready  = (r_state == lpm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign out_free    = !r_ovalid || i_m_tready;

    assign base    = int'(r_in.chain) * lpm_pkg::BEADS;
    assign is_end  = (r_in.bead == 5'd0) || (r_in.bead == 5'(lpm_pkg::BEADS - 1));
    assign addr_k  = lpm_pkg::BEAD_AW'(base + int'(r_in.bead));
    assign addr_n1 = (r_in.bead == 5'd0) ? lpm_pkg::BEAD_AW'(base + 1) :
                     (is_end ? lpm_pkg::BEAD_AW'(base + lpm_pkg::BEADS - 2) :
                               lpm_pkg::BEAD_AW'(base + int'(r_in.bead) - 1));
    assign addr_n2 = lpm_pkg::BEAD_AW'(base + int'(r_in.bead) + 1);

    assign item_bad = !(r_in.action == lpm_pkg::ACT_LOAD || r_in.action == lpm_pkg::ACT_MOVE ||
                        r_in.action == lpm_pkg::ACT_READ) ||
                      (r_in.chain >= 6'(lpm_pkg::CHAINS)) || (r_in.bead >= 5'(lpm_pkg::BEADS));
    assign load_bad = (r_in.lpos.x >= 3'(lpm_pkg::BOX_X)) || (r_in.lpos.y >= 3'(lpm_pkg::BOX_Y)) ||
                      (r_in.lpos.z >= 5'(lpm_pkg::BOX_Z));
    assign dir_bad  = is_end && (r_in.action == lpm_pkg::ACT_MOVE) &&
                      (r_in.dir > lpm_pkg::DIR_NZ);

    assign cnt_inc = (s_rdata == lpm_pkg::CNT_MAX) ? s_rdata : s_rdata + 10'd1;
    assign cnt_dec = (s_rdata == '0) ? s_rdata : s_rdata - 10'd1;

    assign prev_step = r_step - 4'd1;
    always_comb begin
        if (r_step < 4'd6) begin
            sum_addr = lpm_pkg::f_site(lpm_pkg::f_neighbor(r_o, r_step[2:0]));
        end else if (r_step < 4'd12) begin
            sum_addr = lpm_pkg::f_site(lpm_pkg::f_neighbor(r_t, 3'(r_step - 4'd6)));
        end else begin
            sum_addr = lpm_pkg::f_site(r_t);
        end
    end

    assign diff = $signed({2'b00, r_sum_new}) - $signed({2'b00, r_sum_old}) + 15'sd2;
    assign esum = 34'(r_p1) + $signed({8'b0, r_p2});
    assign e_nonpos = r_e[lpm_pkg::E_W-1] || (r_e == '0);
    assign e_big    = (r_e[lpm_pkg::E_W-2:lpm_pkg::EXP_BITS] != '0);
    assign rf_zero  = (r_in.rf == '0);
    assign exp_acc  = exp_res.one || (exp_res.p >= r_in.rf);

    assign dv  = lpm_pkg::f_dir_vec(r_in.dir);
    assign dot = int'(r_va.x) * int'(r_vc.x) + int'(r_va.y) * int'(r_vc.y) +
                 int'(r_va.z) * int'(r_vc.z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpm_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        b_we      = 1'b0;
        b_waddr   = addr_k;
        b_wdata   = r_in.lpos;
        b_raddr   = addr_k;
        s_we      = 1'b0;
        s_waddr   = r_clr;
        s_wdata   = '0;
        s_raddr   = sum_addr;
        exp_start = 1'b0;
        case (r_state)
            lpm_pkg::ST_CLEAR: begin
                s_we = 1'b1;
                if (r_clr == lpm_pkg::SITE_AW'(lpm_pkg::SITES - 1)) begin
                    n_state = lpm_pkg::ST_IDLE;
                end
            end
            lpm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = lpm_pkg::ST_DECODE;
                end
            end
            lpm_pkg::ST_DECODE: begin
                if (item_bad) begin
                    n_state = lpm_pkg::ST_DONE;
                end else if (r_in.action == lpm_pkg::ACT_LOAD) begin
                    n_state = load_bad ? lpm_pkg::ST_DONE : lpm_pkg::ST_LOAD_RD;
                end else begin
                    n_state = lpm_pkg::ST_RD_BEAD;
                end
            end
            lpm_pkg::ST_LOAD_RD: begin
                b_we    = 1'b1;
                s_raddr = lpm_pkg::f_site(r_in.lpos);
                n_state = lpm_pkg::ST_LOAD_WR;
            end
            lpm_pkg::ST_LOAD_WR: begin
                s_we    = 1'b1;
                s_waddr = lpm_pkg::f_site(r_in.lpos);
                s_wdata = cnt_inc;
                n_state = lpm_pkg::ST_DONE;
            end
            lpm_pkg::ST_RD_BEAD: begin
                n_state = lpm_pkg::ST_RD_N1;
            end
            lpm_pkg::ST_RD_N1: begin
                b_raddr = addr_n1;
                if (r_in.action == lpm_pkg::ACT_READ || dir_bad) begin
                    n_state = lpm_pkg::ST_DONE;
                end else begin
                    n_state = lpm_pkg::ST_RD_N2;
                end
            end
            lpm_pkg::ST_RD_N2: begin
                b_raddr = addr_n2;
                n_state = lpm_pkg::ST_GEOM1;
            end
            lpm_pkg::ST_GEOM1: n_state = lpm_pkg::ST_GEOM2;
            lpm_pkg::ST_GEOM2: n_state = lpm_pkg::ST_SUM;
            lpm_pkg::ST_SUM: begin
                if (r_step == lpm_pkg::SUM_LAST) begin
                    n_state = lpm_pkg::ST_MUL1;
                end
            end
            lpm_pkg::ST_MUL1: n_state = lpm_pkg::ST_MUL2;
            lpm_pkg::ST_MUL2: n_state = lpm_pkg::ST_SAT;
            lpm_pkg::ST_SAT:  n_state = lpm_pkg::ST_DECIDE;
            lpm_pkg::ST_DECIDE: begin
                if (e_nonpos || (e_big && rf_zero)) begin
                    n_state = lpm_pkg::ST_UPD_RDO;
                end else if (e_big) begin
                    n_state = lpm_pkg::ST_DONE;
                end else begin
                    exp_start = 1'b1;
                    n_state   = lpm_pkg::ST_EXP;
                end
            end
            lpm_pkg::ST_EXP: begin
                if (exp_res.done) begin
                    n_state = exp_acc ? lpm_pkg::ST_UPD_RDO : lpm_pkg::ST_DONE;
                end
            end
            lpm_pkg::ST_UPD_RDO: begin
                s_raddr = lpm_pkg::f_site(r_o);
                n_state = lpm_pkg::ST_UPD_WRO;
            end
            lpm_pkg::ST_UPD_WRO: begin
                s_we    = 1'b1;
                s_waddr = lpm_pkg::f_site(r_o);
                s_wdata = cnt_dec;
                n_state = lpm_pkg::ST_UPD_RDT;
            end
            lpm_pkg::ST_UPD_RDT: begin
                s_raddr = lpm_pkg::f_site(r_t);
                n_state = lpm_pkg::ST_UPD_WRT;
            end
            lpm_pkg::ST_UPD_WRT: begin
                s_we    = 1'b1;
                s_waddr = lpm_pkg::f_site(r_t);
                s_wdata = cnt_inc;
                b_we    = 1'b1;
                b_wdata = r_t;
                n_state = lpm_pkg::ST_DONE;
            end
            lpm_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = lpm_pkg::ST_IDLE;
                end
            end
            default: n_state = lpm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_be  <= '0;
            r_oe  <= 16'd51200;
        end else begin
            if (r_state == lpm_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lpm_pkg::REG_BEAD_ENERGY:    r_be <= $signed(i_cfg_data);
                    lpm_pkg::REG_OVERLAP_ENERGY: r_oe <= i_cfg_data;
                    default: r_oe <= r_oe;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lpm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_in.action <= i_s_tuser;
                    r_in.chain  <= i_s_tdata[5:0];
                    r_in.bead   <= i_s_tdata[10:6];
                    r_in.dir    <= i_s_tdata[13:11];
                    r_in.lpos.x <= i_s_tdata[16:14];
                    r_in.lpos.y <= i_s_tdata[19:17];
                    r_in.lpos.z <= i_s_tdata[24:20];
                    r_in.rf     <= i_s_tdata[56:25];
                end
            end
            lpm_pkg::ST_DECODE: begin
                r_res <= '{accepted: 1'b0, pos: '0, energy: '0, status: 1'b1};
            end
            lpm_pkg::ST_LOAD_WR: begin
                r_res <= '{accepted: 1'b0, pos: r_in.lpos, energy: '0, status: 1'b0};
            end
            lpm_pkg::ST_RD_N1: begin
                r_o   <= b_rdata;
                r_res <= '{accepted: 1'b0, pos: b_rdata, energy: '0, status: dir_bad};
            end
            lpm_pkg::ST_RD_N2: begin
                r_n1 <= b_rdata;
            end
            lpm_pkg::ST_GEOM1: begin
                if (is_end) begin
                    if (r_in.bead == 5'd0) begin
                        r_va.x <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                            int'(r_n1.x) - int'(r_o.x), lpm_pkg::BOX_X));
                        r_va.y <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                            int'(r_n1.y) - int'(r_o.y), lpm_pkg::BOX_Y));
                        r_va.z <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                            int'(r_n1.z) - int'(r_o.z), lpm_pkg::BOX_Z));
                    end else begin
                        r_va.x <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                            int'(r_o.x) - int'(r_n1.x), lpm_pkg::BOX_X));
                        r_va.y <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                            int'(r_o.y) - int'(r_n1.y), lpm_pkg::BOX_Y));
                        r_va.z <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                            int'(r_o.z) - int'(r_n1.z), lpm_pkg::BOX_Z));
                    end
                end else begin
                    r_va.x <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                        int'(b_rdata[2:0]) - int'(r_o.x), lpm_pkg::BOX_X));
                    r_va.y <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                        int'(b_rdata[5:3]) - int'(r_o.y), lpm_pkg::BOX_Y));
                    r_va.z <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                        int'(b_rdata[10:6]) - int'(r_o.z), lpm_pkg::BOX_Z));
                end
                r_vc.x <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                    int'(r_o.x) - int'(r_n1.x), lpm_pkg::BOX_X));
                r_vc.y <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                    int'(r_o.y) - int'(r_n1.y), lpm_pkg::BOX_Y));
                r_vc.z <= lpm_pkg::t_sc'(lpm_pkg::f_min_image(
                    int'(r_o.z) - int'(r_n1.z), lpm_pkg::BOX_Z));
            end
            lpm_pkg::ST_GEOM2: begin
                r_t <= r_o;
                if (is_end) begin
                    if (r_va != dv) begin
                        if (r_in.bead == 5'd0) begin
                            r_t.x <= 3'(lpm_pkg::f_wrap(int'(r_n1.x) - int'(dv.x), lpm_pkg::BOX_X));
                            r_t.y <= 3'(lpm_pkg::f_wrap(int'(r_n1.y) - int'(dv.y), lpm_pkg::BOX_Y));
                            r_t.z <= 5'(lpm_pkg::f_wrap(int'(r_n1.z) - int'(dv.z), lpm_pkg::BOX_Z));
                        end else begin
                            r_t.x <= 3'(lpm_pkg::f_wrap(int'(r_n1.x) + int'(dv.x), lpm_pkg::BOX_X));
                            r_t.y <= 3'(lpm_pkg::f_wrap(int'(r_n1.y) + int'(dv.y), lpm_pkg::BOX_Y));
                            r_t.z <= 5'(lpm_pkg::f_wrap(int'(r_n1.z) + int'(dv.z), lpm_pkg::BOX_Z));
                        end
                    end
                end else if (dot == 0) begin
                    r_t.x <= 3'(lpm_pkg::f_wrap(int'(r_n1.x) + int'(r_va.x), lpm_pkg::BOX_X));
                    r_t.y <= 3'(lpm_pkg::f_wrap(int'(r_n1.y) + int'(r_va.y), lpm_pkg::BOX_Y));
                    r_t.z <= 5'(lpm_pkg::f_wrap(int'(r_n1.z) + int'(r_va.z), lpm_pkg::BOX_Z));
                end
                r_step    <= '0;
                r_sum_old <= '0;
                r_sum_new <= '0;
            end
            lpm_pkg::ST_SUM: begin
                if (r_step != lpm_pkg::SUM_LAST) begin
                    r_step <= r_step + 4'd1;
                end
                if (r_step != 4'd0) begin
                    if (prev_step < 4'd6) begin
                        r_sum_old <= r_sum_old + 13'(s_rdata);
                    end else if (prev_step < 4'd12) begin
                        r_sum_new <= r_sum_new + 13'(s_rdata);
                    end else begin
                        r_tcount <= s_rdata;
                    end
                end
            end
            lpm_pkg::ST_MUL1: begin
                r_p1 <= 32'(diff) * 32'(r_be);
            end
            lpm_pkg::ST_MUL2: begin
                r_p2 <= 26'(r_tcount) * 26'(r_oe);
            end
            lpm_pkg::ST_SAT: begin
                if (esum > 34'(lpm_pkg::E_MAX)) begin
                    r_e <= lpm_pkg::E_MAX;
                end else if (esum < 34'(lpm_pkg::E_MIN)) begin
                    r_e <= lpm_pkg::E_MIN;
                end else begin
                    r_e <= esum[lpm_pkg::E_W-1:0];
                end
            end
            lpm_pkg::ST_DECIDE, lpm_pkg::ST_EXP: begin
                r_res <= '{accepted: 1'b0, pos: r_o, energy: r_e, status: 1'b0};
            end
            lpm_pkg::ST_UPD_WRT: begin
                r_res <= '{accepted: 1'b1, pos: r_t, energy: r_e, status: 1'b0};
            end
            default: r_step <= r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == lpm_pkg::ST_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lpm_pkg::ST_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {4'b0, r_out.energy, r_out.pos.z, r_out.pos.y, r_out.pos.x,
                         r_out.accepted};

endmodule
`default_nettype wire

[rtl/core/lpm_checker.sv]
// Port-level checker for the lattice polymer move engine, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module lpm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [0:0]  o_m_tuser,
    input wire [39:0] o_m_tdata
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input taken during the clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transaction taken while an item is in progress");

    a_error_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> !o_m_tdata[0])
        else $error("result flags both an error and an accepted move");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind lattice_polymer_metropolis_move lpm_checker u_lpm_checker (.*);
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for lattice_polymer_metropolis_move: loads chains, reads and
// moves beads under several energy settings, and checks every result against a predictor.
// Depends on lpm_pkg and the RTL of the block.
`default_nettype none
module tb;
    import lpm_pkg::*;

    typedef struct packed {
        logic [1:0]  act;
        logic [5:0]  chain;
        logic [4:0]  bead;
        logic [2:0]  dir;
        logic [2:0]  lx;
        logic [2:0]  ly;
        logic [4:0]  lz;
        logic [31:0] rf;
    } move_item_t;

    typedef struct packed {
        logic        status;
        logic [39:0] data;
    } move_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [0:0]  m_tuser;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    move_item_t   pending_items[$];
    move_result_t expected_results[$];
    int           errors = 0;
    int           results_seen = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    bit           quiet = 1'b0;
    move_item_t   offered;

    t_pos             bead_pos [CHAINS][BEADS];
    logic [CNT_W-1:0] site_cnt [SITES];
    logic signed [15:0] bead_en = 16'sd0;
    logic [15:0]        overlap_en = 16'd51200;
    bit               chain_loaded [CHAINS];

    lattice_polymer_metropolis_move dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tuser(s_tuser),
        .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tuser(m_tuser),
        .o_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int wrap_len(input int v, input int len);
        return ((v % len) + len) % len;
    endfunction

    function automatic int nearest_image(input int d, input int len);
        if (2 * d > len) return d - len;
        if (2 * d <= -len) return d + len;
        return d;
    endfunction

    function automatic int site_index(input int x, input int y, input int z);
        return x + BOX_X * y + BOX_X * BOX_Y * z;
    endfunction

    function automatic int contact_sum(input int x, input int y, input int z);
        int s;
        s = site_cnt[site_index(wrap_len(x + 1, BOX_X), y, z)]
          + site_cnt[site_index(wrap_len(x - 1, BOX_X), y, z)]
          + site_cnt[site_index(x, wrap_len(y + 1, BOX_Y), z)]
          + site_cnt[site_index(x, wrap_len(y - 1, BOX_Y), z)]
          + site_cnt[site_index(x, y, wrap_len(z + 1, BOX_Z))]
          + site_cnt[site_index(x, y, wrap_len(z - 1, BOX_Z))];
        return s;
    endfunction

    function automatic logic [63:0] boltzmann_weight(input longint e);
        logic [63:0] p;
        p = 64'd1 << 32;
        if (e >= 32 * 256) return 64'd0;
        for (int b = 0; b < EXP_BITS; b++) begin
            if (e[b]) p = (p * EXP_FACTOR[b]) >> 32;
        end
        return p;
    endfunction

    function automatic move_result_t predict_move(input move_item_t it);
        move_result_t r;
        int ox, oy, oz, tx, ty, tz, nb, dx, dy, dz, bx, by, bz, ax, ay, az, cx, cy, cz;
        int os, ts, sgn;
        longint e;
        logic acc;
        r = '0;
        if (it.act > ACT_READ || it.chain >= CHAINS || it.bead >= BEADS) begin
            r.status = 1'b1;
            return r;
        end
        if (it.act == ACT_LOAD) begin
            if (it.lx >= BOX_X || it.ly >= BOX_Y || it.lz >= BOX_Z) begin
                r.status = 1'b1;
                return r;
            end
            bead_pos[it.chain][it.bead] = '{z: it.lz, y: it.ly, x: it.lx};
            os = site_index(it.lx, it.ly, it.lz);
            if (site_cnt[os] != CNT_MAX) site_cnt[os]++;
            r.data = {4'b0, 24'd0, it.lz, it.ly, it.lx, 1'b0};
            return r;
        end
        ox = bead_pos[it.chain][it.bead].x;
        oy = bead_pos[it.chain][it.bead].y;
        oz = bead_pos[it.chain][it.bead].z;
        r.data = {4'b0, 24'd0, 5'(oz), 3'(oy), 3'(ox), 1'b0};
        if (it.act == ACT_READ) return r;
        tx = ox; ty = oy; tz = oz;
        if (it.bead == 0 || it.bead == BEADS - 1) begin
            if (it.dir > DIR_NZ) begin
                r.status = 1'b1;
                return r;
            end
            nb = (it.bead == 0) ? 1 : BEADS - 2;
            dx = (it.dir == DIR_PX) ? 1 : (it.dir == DIR_NX) ? -1 : 0;
            dy = (it.dir == DIR_PY) ? 1 : (it.dir == DIR_NY) ? -1 : 0;
            dz = (it.dir == DIR_PZ) ? 1 : (it.dir == DIR_NZ) ? -1 : 0;
            sgn = (it.bead == 0) ? -1 : 1;
            bx = nearest_image(-sgn * (bead_pos[it.chain][nb].x - ox), BOX_X);
            by = nearest_image(-sgn * (bead_pos[it.chain][nb].y - oy), BOX_Y);
            bz = nearest_image(-sgn * (bead_pos[it.chain][nb].z - oz), BOX_Z);
            if (!(bx == dx && by == dy && bz == dz)) begin
                tx = wrap_len(bead_pos[it.chain][nb].x + sgn * dx, BOX_X);
                ty = wrap_len(bead_pos[it.chain][nb].y + sgn * dy, BOX_Y);
                tz = wrap_len(bead_pos[it.chain][nb].z + sgn * dz, BOX_Z);
            end
        end else begin
            ax = nearest_image(bead_pos[it.chain][it.bead + 1].x - ox, BOX_X);
            ay = nearest_image(bead_pos[it.chain][it.bead + 1].y - oy, BOX_Y);
            az = nearest_image(bead_pos[it.chain][it.bead + 1].z - oz, BOX_Z);
            cx = nearest_image(ox - bead_pos[it.chain][it.bead - 1].x, BOX_X);
            cy = nearest_image(oy - bead_pos[it.chain][it.bead - 1].y, BOX_Y);
            cz = nearest_image(oz - bead_pos[it.chain][it.bead - 1].z, BOX_Z);
            if (ax * cx + ay * cy + az * cz == 0) begin
                tx = wrap_len(bead_pos[it.chain][it.bead - 1].x + ax, BOX_X);
                ty = wrap_len(bead_pos[it.chain][it.bead - 1].y + ay, BOX_Y);
                tz = wrap_len(bead_pos[it.chain][it.bead - 1].z + az, BOX_Z);
            end
        end
        os = site_index(ox, oy, oz);
        ts = site_index(tx, ty, tz);
        e = longint'((contact_sum(tx, ty, tz) + 1) - (contact_sum(ox, oy, oz) - 1))
            * longint'(bead_en) + longint'(site_cnt[ts]) * longint'(overlap_en);
        if (e > 8388607) e = 8388607;
        if (e < -8388608) e = -8388608;
        acc = (e <= 0) || (boltzmann_weight(e) >= {32'd0, it.rf});
        if (acc) begin
            if (site_cnt[os] != 0) site_cnt[os]--;
            bead_pos[it.chain][it.bead] = '{z: 5'(tz), y: 3'(ty), x: 3'(tx)};
            if (site_cnt[ts] != CNT_MAX) site_cnt[ts]++;
            r.data = {4'b0, 24'(e), 5'(tz), 3'(ty), 3'(tx), 1'b1};
        end else begin
            r.data = {4'b0, 24'(e), 5'(oz), 3'(oy), 3'(ox), 1'b0};
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_move(offered));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    offered = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= offered.act;
                    s_tdata <= {7'd0, offered.rf, offered.lz, offered.ly, offered.lx,
                                offered.dir, offered.bead, offered.chain};
                    if (!quiet && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        move_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[0] !== want.status)
                    report_mismatch("status", {39'd0, m_tuser}, {39'd0, want.status});
                if (m_tdata[0] !== want.data[0])
                    report_mismatch("accepted", m_tdata, want.data);
                if (m_tdata[11:1] !== want.data[11:1])
                    report_mismatch("bead position", m_tdata, want.data);
                if (m_tdata[35:12] !== want.data[35:12])
                    report_mismatch("energy delta", m_tdata, want.data);
                if (m_tdata[39:36] !== 4'd0)
                    report_mismatch("padding", m_tdata, want.data);
            end
        end
    end

    task automatic write_register(input logic [0:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        if (idx == REG_BEAD_ENERGY) bead_en = val;
        else overlap_en = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic move_item_t make_item(input logic [1:0] act, input int c, input int b);
        move_item_t it;
        it.act = act;
        it.chain = 6'(c);
        it.bead = 5'(b);
        it.dir = 3'($urandom_range(0, 5));
        it.lx = 3'($urandom_range(0, 7));
        it.ly = 3'($urandom_range(0, 7));
        it.lz = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 5))
            0: it.rf = 32'd0;
            1: it.rf = 32'hFFFF_FFFF;
            2: it.rf = 32'($urandom_range(0, 65535)) << 16;
            default: it.rf = $urandom;
        endcase
        return it;
    endfunction

    task automatic load_chain(input int c);
        move_item_t it;
        int x, y, z, d;
        x = $urandom_range(0, BOX_X - 1);
        y = $urandom_range(0, BOX_Y - 1);
        z = $urandom_range(0, BOX_Z - 1);
        for (int b = 0; b < BEADS; b++) begin
            it = make_item(ACT_LOAD, c, b);
            it.lx = 3'(x); it.ly = 3'(y); it.lz = 5'(z);
            pending_items.push_back(it);
            d = $urandom_range(0, 5);
            case (d)
                0: x = wrap_len(x + 1, BOX_X);
                1: x = wrap_len(x - 1, BOX_X);
                2: y = wrap_len(y + 1, BOX_Y);
                3: y = wrap_len(y - 1, BOX_Y);
                4: z = wrap_len(z + 1, BOX_Z);
                default: z = wrap_len(z - 1, BOX_Z);
            endcase
        end
        chain_loaded[c] = 1'b1;
    endtask

    function automatic int pick_loaded_chain();
        int c;
        do c = $urandom_range(0, CHAINS - 1); while (!chain_loaded[c]);
        return c;
    endfunction

    task automatic add_noise();
        move_item_t it;
        it = make_item(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 31));
        case ($urandom_range(0, 4))
            0: it.chain = 6'($urandom_range(CHAINS, 63));
            1: it.bead = 5'($urandom_range(BEADS, 31));
            2: it.act = 2'd3;
            3: begin
                it.act = ACT_LOAD;
                it.chain = 6'($urandom_range(0, CHAINS - 1));
                it.bead = 5'($urandom_range(0, BEADS - 1));
                it.lz = 5'($urandom_range(BOX_Z, 31));
            end
            default: begin
                it.act = ACT_MOVE;
                it.chain = 6'(pick_loaded_chain());
                it.bead = ($urandom_range(0, 1) != 0) ? 5'(BEADS - 1) : 5'd0;
                it.dir = 3'($urandom_range(6, 7));
            end
        endcase
        if (it.act != ACT_LOAD && it.chain < CHAINS && it.bead < BEADS && it.act != 2'd3
            && !chain_loaded[it.chain]) it.act = ACT_LOAD;
        pending_items.push_back(it);
    endtask

    task automatic add_random_phase(input int count);
        move_item_t it;
        int r, b;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                load_chain($urandom_range(0, CHAINS - 1));
                n += BEADS - 1;
            end else if (r < 8) begin
                add_noise();
            end else begin
                b = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) != 0) ? BEADS - 1 : 0)
                                                : $urandom_range(0, BEADS - 1);
                it = make_item((r < 14) ? ACT_READ : ACT_MOVE, pick_loaded_chain(), b);
                if (b != 0 && b != BEADS - 1) it.dir = 3'($urandom_range(0, 7));
                pending_items.push_back(it);
            end
        end
    endtask

    initial begin
        move_item_t it;
        for (int c = 0; c < CHAINS; c++) begin
            chain_loaded[c] = 1'b0;
            for (int b = 0; b < BEADS; b++) bead_pos[c][b] = '0;
        end
        for (int s = 0; s < SITES; s++) site_cnt[s] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_chain(0);
        it = make_item(ACT_LOAD, 1, 0); it.lx = 3'd7; it.ly = 3'd0; it.lz = 5'd0;
        pending_items.push_back(it);
        it = make_item(ACT_LOAD, 1, 0); it.lx = 3'd0; it.ly = 3'd7; it.lz = 5'd19;
        pending_items.push_back(it);
        it = make_item(ACT_LOAD, 1, 0); it.lx = 3'd6; it.ly = 3'd6; it.lz = 5'd20;
        pending_items.push_back(it);
        it = make_item(ACT_READ, 63, 0); pending_items.push_back(it);
        it = make_item(ACT_MOVE, 0, 31); pending_items.push_back(it);
        it = make_item(2'd3, 0, 0); pending_items.push_back(it);
        it = make_item(ACT_READ, 0, BEADS - 1); pending_items.push_back(it);
        it = make_item(ACT_MOVE, 0, 0); it.dir = 3'd6; pending_items.push_back(it);
        it = make_item(ACT_MOVE, 0, BEADS - 1); it.dir = 3'd7; pending_items.push_back(it);
        for (int d = DIR_PX; d <= DIR_NZ; d++) begin
            it = make_item(ACT_MOVE, 0, (d % 2 == 0) ? 0 : BEADS - 1);
            it.dir = 3'(d);
            it.rf = (d < 3) ? 32'd0 : 32'hFFFF_FFFF;
            pending_items.push_back(it);
        end
        it = make_item(ACT_MOVE, 0, 7); pending_items.push_back(it);
        it = make_item(ACT_MOVE, 0, 12); pending_items.push_back(it);
        wait_drained();

        for (int c = 1; c < 8; c++) load_chain(c * 5);
        add_random_phase(150);
        wait_drained();

        write_register(REG_BEAD_ENERGY, 16'h8000);
        write_register(REG_OVERLAP_ENERGY, 16'd0);
        add_random_phase(300);
        wait_drained();

        write_register(REG_BEAD_ENERGY, 16'h7FFF);
        write_register(REG_OVERLAP_ENERGY, 16'hFFFF);
        add_random_phase(300);
        wait_drained();

        write_register(REG_BEAD_ENERGY, 16'($urandom_range(0, 1023)) - 16'd512);
        write_register(REG_OVERLAP_ENERGY, 16'($urandom_range(0, 1023)));
        add_random_phase(300);
        wait_drained();

        write_register(REG_BEAD_ENERGY, 16'($urandom));
        write_register(REG_OVERLAP_ENERGY, 16'($urandom));
        add_random_phase(200);
        wait_drained();

        quiet = 1'b1;
        write_register(REG_BEAD_ENERGY, 16'($urandom_range(0, 255)));
        write_register(REG_OVERLAP_ENERGY, 16'($urandom_range(0, 2047)));
        add_random_phase(150);
        wait_drained();

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #15000000;
        $display("tb failed");
        $finish;
    end

endmodule
`default_nettype wire
